@@ rtl/pffla_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package pffla_pkg;

    localparam int CMD_W  = 2;
    localparam int CNT_W  = 8;
    localparam int IDX_W  = 7;
    localparam int ST_W   = 2;
    localparam int ADDR_W = 28;

    localparam logic [CMD_W-1:0] CMD_ALLOC = 2'd0;
    localparam logic [CMD_W-1:0] CMD_FREE  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_INIT  = 2'd2;
    localparam logic [CMD_W-1:0] CMD_NONE  = 2'd3;

    localparam logic [ST_W-1:0] ST_ALLOC_OK = 2'd0;
    localparam logic [ST_W-1:0] ST_ZERO     = 2'd1;
    localparam logic [ST_W-1:0] ST_SHORT    = 2'd2;
    localparam logic [ST_W-1:0] ST_DONE     = 2'd3;

    typedef enum logic [3:0] {
        DP_NOP,
        DP_CLR_START,
        DP_CLR_STEP,
        DP_LOAD_ALLOC,
        DP_LOAD_FREE,
        DP_A_STEP,
        DP_A_LINK,
        DP_A_FIX,
        DP_F_BACK,
        DP_F_TURN,
        DP_F_FWD,
        DP_F_SPLICE,
        DP_RESULT
    } t_dp_op;

    typedef struct packed {
        t_dp_op          op;
        logic [ST_W-1:0] status;
    } t_dp_cmd;

    typedef struct packed {
        logic cnt_zero;
        logic page_ok;
        logic fh_page;
        logic k_lt_cnt;
        logic nrd_page;
        logic prd_page;
        logic steps_done;
        logic head_is_fh;
        logic sweep_last;
    } t_dp_sts;

endpackage
`default_nettype wire

@@ rtl/pffla_dp.sv @@
`timescale 1ns / 1ps
`default_nettype none
module pffla_dp #(
    parameter int PAGE_COUNT = 128,
    parameter int PAGE_SHIFT = 21
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire pffla_pkg::t_dp_cmd            i_cmd,
    output pffla_pkg::t_dp_sts                 o_sts,
    input  wire logic [pffla_pkg::CNT_W-1:0]   i_page_count,
    input  wire logic [pffla_pkg::IDX_W-1:0]   i_page_index,
    output logic      [pffla_pkg::ST_W-1:0]    o_status,
    output logic      [pffla_pkg::IDX_W-1:0]   o_first_page,
    output logic      [pffla_pkg::ADDR_W-1:0]  o_first_address
);
    localparam int LW = $clog2(PAGE_COUNT + 1);
    localparam int PW = $clog2(PAGE_COUNT);
    localparam int CW = (LW > pffla_pkg::CNT_W) ? LW : pffla_pkg::CNT_W;
    localparam int SW = LW + PAGE_SHIFT;
    localparam int XW = (SW > pffla_pkg::ADDR_W) ? SW : pffla_pkg::ADDR_W;
    localparam logic [LW-1:0] NIL  = LW'(PAGE_COUNT);
    localparam logic [LW-1:0] LAST = LW'(PAGE_COUNT - 1);

    logic [LW-1:0] r_next_mem [PAGE_COUNT];
    logic [LW-1:0] r_prev_mem [PAGE_COUNT];

    logic [LW-1:0] r_fh;
    logic [LW-1:0] r_head;
    logic [LW-1:0] r_tail;
    logic [LW-1:0] r_nrd;
    logic [LW-1:0] r_prd;
    logic [CW-1:0] r_k;
    logic [pffla_pkg::CNT_W-1:0] r_cnt;

    logic          n_we_next;
    logic [PW-1:0] n_wa_next;
    logic [LW-1:0] n_wd_next;
    logic          n_we_prev;
    logic [PW-1:0] n_wa_prev;
    logic [LW-1:0] n_wd_prev;
    logic [XW-1:0] w_addr_full;

    assign o_sts.cnt_zero   = (i_page_count == '0);
    assign o_sts.page_ok    = (32'(i_page_index) < 32'(PAGE_COUNT));
    assign o_sts.fh_page    = (r_fh < NIL);
    assign o_sts.k_lt_cnt   = (r_k < CW'(r_cnt));
    assign o_sts.nrd_page   = (r_nrd < NIL);
    assign o_sts.prd_page   = (r_prd < NIL);
    assign o_sts.steps_done = (r_k == CW'(PAGE_COUNT));
    assign o_sts.head_is_fh = (r_head == r_fh);
    assign o_sts.sweep_last = (r_k == CW'(PAGE_COUNT - 1));

    assign w_addr_full = XW'(r_head) << PAGE_SHIFT;

    // write port selection
    always_comb begin
        n_we_next = 1'b0;
        n_wa_next = r_tail[PW-1:0];
        n_wd_next = NIL;
        n_we_prev = 1'b0;
        n_wa_prev = r_head[PW-1:0];
        n_wd_prev = NIL;
        unique case (i_cmd.op)
            pffla_pkg::DP_CLR_STEP: begin
                n_we_next = 1'b1;
                n_wa_next = r_k[PW-1:0];
                n_wd_next = (r_k == '0) ? NIL : LW'(r_k - 1'b1);
                n_we_prev = 1'b1;
                n_wa_prev = r_k[PW-1:0];
                n_wd_prev = (r_k == CW'(PAGE_COUNT - 1)) ? NIL : LW'(r_k + 1'b1);
            end
            pffla_pkg::DP_A_LINK: begin
                n_we_next = 1'b1;
                n_we_prev = (r_nrd < NIL);
                n_wa_prev = r_nrd[PW-1:0];
            end
            pffla_pkg::DP_A_FIX: begin
                n_we_prev = 1'b1;
            end
            pffla_pkg::DP_F_SPLICE: begin
                n_we_next = 1'b1;
                n_wd_next = r_fh;
                n_we_prev = (r_fh < NIL);
                n_wa_prev = r_fh[PW-1:0];
                n_wd_prev = r_tail;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (n_we_next) begin
            r_next_mem[n_wa_next] <= n_wd_next;
        end
        r_nrd <= r_next_mem[r_tail[PW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (n_we_prev) begin
            r_prev_mem[n_wa_prev] <= n_wd_prev;
        end
        r_prd <= r_prev_mem[r_head[PW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k  <= '0;
            r_fh <= LAST;
        end else begin
            unique case (i_cmd.op)
                pffla_pkg::DP_CLR_START: r_k <= '0;
                pffla_pkg::DP_CLR_STEP: begin
                    r_k <= r_k + 1'b1;
                    if (r_k == CW'(PAGE_COUNT - 1)) begin
                        r_fh <= LAST;
                    end
                end
                pffla_pkg::DP_LOAD_ALLOC: begin
                    r_head <= r_fh;
                    r_tail <= r_fh;
                    r_cnt  <= i_page_count;
                    r_k    <= CW'(1);
                end
                pffla_pkg::DP_LOAD_FREE: begin
                    r_head <= LW'(i_page_index);
                    r_k    <= '0;
                end
                pffla_pkg::DP_A_STEP: begin
                    r_tail <= r_nrd;
                    r_k    <= r_k + 1'b1;
                end
                pffla_pkg::DP_A_LINK: r_fh <= r_nrd;
                pffla_pkg::DP_F_BACK: begin
                    r_head <= r_prd;
                    r_k    <= r_k + 1'b1;
                end
                pffla_pkg::DP_F_TURN: begin
                    r_tail <= r_head;
                    r_k    <= '0;
                end
                pffla_pkg::DP_F_FWD: begin
                    r_tail <= r_nrd;
                    r_k    <= r_k + 1'b1;
                end
                pffla_pkg::DP_F_SPLICE: r_fh <= r_head;
                pffla_pkg::DP_RESULT: begin
                    o_status <= i_cmd.status;
                    if (i_cmd.status == pffla_pkg::ST_ALLOC_OK) begin
                        o_first_page    <= pffla_pkg::IDX_W'(r_head);
                        o_first_address <= w_addr_full[pffla_pkg::ADDR_W-1:0];
                    end else begin
                        o_first_page    <= '0;
                        o_first_address <= '0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

endmodule
`default_nettype wire

@@ rtl/pffla_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
module pffla_ctrl (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic [pffla_pkg::CMD_W-1:0]   i_command,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output pffla_pkg::t_dp_cmd                 o_cmd,
    input  wire pffla_pkg::t_dp_sts            i_sts
);
    typedef enum logic [3:0] {
        S_CLEAR,
        S_INIT,
        S_IDLE,
        S_A_WAIT,
        S_A_STEP,
        S_A_FIX,
        S_F_WAIT_B,
        S_F_BACK,
        S_F_WAIT_F,
        S_F_FWD,
        S_DONE
    } t_state;

    t_state                     r_state;
    logic [pffla_pkg::ST_W-1:0] r_status;
    logic                       w_accept;
    logic                       w_out_free;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_out_free = !o_out_valid || i_out_ready;

    always_comb begin
        o_cmd.op     = pffla_pkg::DP_NOP;
        o_cmd.status = r_status;
        unique case (r_state)
            S_CLEAR, S_INIT: o_cmd.op = pffla_pkg::DP_CLR_STEP;
            S_IDLE: begin
                if (w_accept) begin
                    priority if (i_command == pffla_pkg::CMD_ALLOC) begin
                        if (!i_sts.cnt_zero && i_sts.fh_page) begin
                            o_cmd.op = pffla_pkg::DP_LOAD_ALLOC;
                        end
                    end else if (i_command == pffla_pkg::CMD_FREE) begin
                        if (i_sts.page_ok) begin
                            o_cmd.op = pffla_pkg::DP_LOAD_FREE;
                        end
                    end else if (i_command == pffla_pkg::CMD_INIT) begin
                        o_cmd.op = pffla_pkg::DP_CLR_START;
                    end else begin
                        // unused command: nothing to do in the datapath
                    end
                end
            end
            S_A_STEP: begin
                if (!i_sts.k_lt_cnt) begin
                    o_cmd.op = pffla_pkg::DP_A_LINK;
                end else if (i_sts.nrd_page) begin
                    o_cmd.op = pffla_pkg::DP_A_STEP;
                end
            end
            S_A_FIX: o_cmd.op = pffla_pkg::DP_A_FIX;
            S_F_BACK: begin
                if (i_sts.steps_done || !i_sts.prd_page) begin
                    if (!i_sts.head_is_fh) begin
                        o_cmd.op = pffla_pkg::DP_F_TURN;
                    end
                end else begin
                    o_cmd.op = pffla_pkg::DP_F_BACK;
                end
            end
            S_F_FWD: begin
                if (i_sts.steps_done || !i_sts.nrd_page) begin
                    o_cmd.op = pffla_pkg::DP_F_SPLICE;
                end else begin
                    o_cmd.op = pffla_pkg::DP_F_FWD;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    o_cmd.op = pffla_pkg::DP_RESULT;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_status    <= pffla_pkg::ST_DONE;
            o_out_valid <= 1'b0;
        end else begin
            if (r_state == S_DONE && w_out_free) begin
                o_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                o_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    if (i_sts.sweep_last) begin
                        r_state <= S_IDLE;
                    end
                end
                S_INIT: begin
                    if (i_sts.sweep_last) begin
                        r_status <= pffla_pkg::ST_DONE;
                        r_state  <= S_DONE;
                    end
                end
                S_IDLE: begin
                    if (w_accept) begin
                        r_status <= pffla_pkg::ST_DONE;
                        r_state  <= S_DONE;
                        priority if (i_command == pffla_pkg::CMD_ALLOC) begin
                            priority if (i_sts.cnt_zero) begin
                                r_status <= pffla_pkg::ST_ZERO;
                            end else if (!i_sts.fh_page) begin
                                r_status <= pffla_pkg::ST_SHORT;
                            end else begin
                                r_state <= S_A_WAIT;
                            end
                        end else if (i_command == pffla_pkg::CMD_FREE) begin
                            if (i_sts.page_ok) begin
                                r_state <= S_F_WAIT_B;
                            end
                        end else if (i_command == pffla_pkg::CMD_INIT) begin
                            r_state <= S_INIT;
                        end else begin
                            // unused command: straight to the result
                        end
                    end
                end
                S_A_WAIT: r_state <= S_A_STEP;
                S_A_STEP: begin
                    priority if (!i_sts.k_lt_cnt) begin
                        r_state <= S_A_FIX;
                    end else if (i_sts.nrd_page) begin
                        r_state <= S_A_WAIT;
                    end else begin
                        r_status <= pffla_pkg::ST_SHORT;
                        r_state  <= S_DONE;
                    end
                end
                S_A_FIX: begin
                    r_status <= pffla_pkg::ST_ALLOC_OK;
                    r_state  <= S_DONE;
                end
                S_F_WAIT_B: r_state <= S_F_BACK;
                S_F_BACK: begin
                    if (i_sts.steps_done || !i_sts.prd_page) begin
                        r_state <= i_sts.head_is_fh ? S_DONE : S_F_WAIT_F;
                    end else begin
                        r_state <= S_F_WAIT_B;
                    end
                end
                S_F_WAIT_F: r_state <= S_F_FWD;
                S_F_FWD: begin
                    if (i_sts.steps_done || !i_sts.nrd_page) begin
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_F_WAIT_F;
                    end
                end
                S_DONE: begin
                    if (w_out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire

@@ rtl/page_frame_free_list_allocator.sv @@
// Page frame allocator over a pool of PAGE_COUNT frames kept as doubly
// linked lists in two link memories (next and prev, one write and one read port each).
// Input channel (i_in_valid / o_in_ready): one transaction carries a
// command: allocate i_page_count frames, free the list holding
// i_page_index, or rebuild the pool. Output channel (o_out_valid /
// i_out_ready): exactly one result transaction per command, with status,
// first page and its physical address (page << PAGE_SHIFT, 28 bits).
// One command is in flight at a time. Each link hop is a registered
// memory read followed by its use. Allocate walks n frames forward from
// the free head; free walks back to the start of the list, then forward
// to its end, and splices it in front of the free list; rebuild writes
// one frame's links per cycle.
// After reset the block runs a clearing pass that rebuilds the links;
// o_in_ready stays low during it.
// A finished result sits in the output register; a new command is taken
// while it waits, but the next result is held back until the receiver
// has taken the earlier one.
`timescale 1ns / 1ps
`default_nettype none
module page_frame_free_list_allocator #(
    parameter int PAGE_COUNT = 128,
    parameter int PAGE_SHIFT = 21
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic [pffla_pkg::CMD_W-1:0]   i_command,
    input  wire logic [pffla_pkg::CNT_W-1:0]   i_page_count,
    input  wire logic [pffla_pkg::IDX_W-1:0]   i_page_index,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic      [pffla_pkg::ST_W-1:0]    o_status,
    output logic      [pffla_pkg::IDX_W-1:0]   o_first_page,
    output logic      [pffla_pkg::ADDR_W-1:0]  o_first_address
);
    // controller -> datapath commands, datapath -> controller flags
    pffla_pkg::t_dp_cmd w_cmd;
    pffla_pkg::t_dp_sts w_sts;

    pffla_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_command   (i_command),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (w_cmd),
        .i_sts       (w_sts)
    );

    // link memories, walk pointers, free head and result registers
    pffla_dp #(
        .PAGE_COUNT (PAGE_COUNT),
        .PAGE_SHIFT (PAGE_SHIFT)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_sts           (w_sts),
        .i_page_count    (i_page_count),
        .i_page_index    (i_page_index),
        .o_status        (o_status),
        .o_first_page    (o_first_page),
        .o_first_address (o_first_address)
    );

`ifndef SYNTHESIS
    // a command is never taken on two consecutive edges
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("second command taken while one in flight");

    // failed or non-allocate results carry no page
    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status != pffla_pkg::ST_ALLOC_OK) |->
        (o_first_page == '0 && o_first_address == '0))
        else $error("nonzero page on non-allocate result");

    // clearing pass blocks input right after reset
    a_clear_pass: assert property (@(posedge i_clk)
        $rose(i_rst_n) |-> !o_in_ready)
        else $error("input ready during clearing pass");
`endif

endmodule
`default_nettype wire
